// ----- rtl/lottery_slot_arbiter_top_defines.svh -----
`ifndef LOTTERY_SLOT_ARBITER_TOP_DEFINES_SVH
`define LOTTERY_SLOT_ARBITER_TOP_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define LSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define LSA_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ----- rtl/lsa_pkg.sv -----
package lsa_pkg;

  localparam int SLOTS      = 64;
  localparam int MAX_SHIFT  = 15;

  localparam int IDX_W      = $clog2(SLOTS);
  localparam int AW         = IDX_W + 1;
  localparam int PRIO_W     = 8;
  localparam int LFSR_W     = 16;
  localparam int SLOT_IN_W  = 6;
  localparam int TOTAL_W    = 22;
  localparam int SUM_W      = IDX_W + MAX_SHIFT + 1;
  localparam int TRIAL_W    = LFSR_W + 1;
  localparam int CMP_W      = (SUM_W > TRIAL_W) ? SUM_W : TRIAL_W;
  localparam int CNT_W      = $clog2(LFSR_W);

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_ELECT = 1'b1;

  localparam logic CFG_SEED  = 1'b0;
  localparam logic CFG_UPRIO = 1'b1;

  localparam logic [LFSR_W-1:0] SEED_RESET  = 16'd44257;
  localparam logic [PRIO_W-1:0] UPRIO_RESET = 8'd40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAX,
    ST_SUM,
    ST_LAUNCH,
    ST_DIV,
    ST_PICK,
    ST_WB,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic              ready;
    logic [PRIO_W-1:0] prio;
  } mem_wr_t;

  // Tickets of one ready slot: 2^(top - prio), exponent capped.
  function automatic logic [SUM_W-1:0] slot_tickets(input logic [PRIO_W-1:0] top,
                                                    input logic [PRIO_W-1:0] prio);
    logic [PRIO_W-1:0] diff;
    logic [PRIO_W-1:0] sh;
    diff = top - prio;
    sh   = (diff > PRIO_W'(MAX_SHIFT)) ? PRIO_W'(MAX_SHIFT) : diff;
    return SUM_W'(1) << sh;
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[LFSR_W-1:1]};
  endfunction

endpackage

// ----- rtl/lsa_slot_mem.sv -----
module lsa_slot_mem (
  input  logic                          clk,
  input  logic                          rst,
  input  lsa_pkg::mem_wr_t              wr,
  input  logic                          rd_en,
  input  logic [lsa_pkg::IDX_W-1:0]     rd_addr,
  output logic                          rd_ready,
  output logic [lsa_pkg::PRIO_W-1:0]    rd_prio
);
  import lsa_pkg::*;

  logic [PRIO_W:0]   mem [SLOTS];
  logic [SLOTS-1:0]  written;
  logic [PRIO_W:0]   rdata;
  logic              rvalid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.ready, wr.prio};
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Entries never written since reset read as not ready with priority zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rvalid  <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid <= written[rd_addr];
      end
    end
  end

  assign rd_ready = rvalid & rdata[PRIO_W];
  assign rd_prio  = rvalid ? rdata[PRIO_W-1:0] : '0;

endmodule

// ----- rtl/lsa_mod_unit.sv -----
module lsa_mod_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lsa_pkg::LFSR_W-1:0]   dividend,
  input  logic [lsa_pkg::SUM_W-1:0]    divisor,
  output logic                         done,
  output logic [lsa_pkg::LFSR_W-1:0]   remainder
);
  import lsa_pkg::*;

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [LFSR_W-1:0]  dvd;
  logic [LFSR_W-1:0]  rem;
  logic [TRIAL_W-1:0] trial;
  logic [CMP_W-1:0]   diff;
  logic               ge;

  // Restoring remainder, one dividend bit per cycle.
  always_comb begin
    trial = {rem, dvd[LFSR_W-1]};
    ge    = CMP_W'(trial) >= CMP_W'(divisor);
    diff  = CMP_W'(trial) - CMP_W'(divisor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(LFSR_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(LFSR_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[LFSR_W-2:0], 1'b0};
      rem <= ge ? diff[LFSR_W-1:0] : trial[LFSR_W-1:0];
    end
  end

  assign remainder = rem;

endmodule

// ----- rtl/lottery_slot_arbiter_top.sv -----
// Lottery arbiter over a table of slots, each holding a ready flag and a priority.
// Input channel (in_valid/in_stall): func selects a slot write or an election.
// A slot write produces no result transaction. An election produces exactly one
// result transaction on the output channel (out_valid/out_stall) carrying the
// winner, a found flag and the ticket total.
// An election sweeps the slot memory read port to find the top priority, sweeps
// it again to sum tickets, takes the remainder of the next LFSR value by the
// ticket sum and sweeps once more to pick the winner, then writes the winner
// back with user_priority; with no slot ready it skips the remainder and pick.
// One item is worked on at a time; in_stall is high while an election is in
// progress.
// The result sits in an output register; the next transaction is accepted while
// it waits. If a new election finishes while the previous result is still
// stalled, the block holds until the output register frees up.
// Reset (rst, synchronous) empties the slot table (all slots not ready, priority
// zero), clears the LFSR and restores the configuration registers. The first
// election loads the LFSR from seed_value.
`include "lottery_slot_arbiter_top_defines.svh"

module lottery_slot_arbiter_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [lsa_pkg::LFSR_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             func,
  input  logic [lsa_pkg::SLOT_IN_W-1:0]    slot_index,
  input  logic                             ready_in,
  input  logic [lsa_pkg::PRIO_W-1:0]       priority_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [lsa_pkg::SLOT_IN_W-1:0]    winner_slot,
  output logic                             found,
  output logic [lsa_pkg::TOTAL_W-1:0]      ticket_total
);
  import lsa_pkg::*;

  state_t              state;
  state_t              state_next;

  logic [LFSR_W-1:0]   seed_value;
  logic [PRIO_W-1:0]   user_priority;
  logic [LFSR_W-1:0]   lfsr;
  logic                seeded;

  logic [AW-1:0]       walk_addr;
  logic                data_vld;
  logic [IDX_W-1:0]    data_idx;
  logic                walking;
  logic                issue;
  logic                walk_done;

  logic                rd_ready;
  logic [PRIO_W-1:0]   rd_prio;
  mem_wr_t             wr;

  logic [PRIO_W-1:0]   top;
  logic                any_ready;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    acc;
  logic [SUM_W-1:0]    acc_next;
  logic [SUM_W-1:0]    tickets;
  logic [TRIAL_W-1:0]  draw;
  logic                pick_hit;
  logic [IDX_W-1:0]    win;

  logic                mod_start;
  logic                mod_done;
  logic [LFSR_W-1:0]   mod_rem;

  logic                in_accept;
  logic                out_free;
  logic                idx_in_range;
  logic [31:0]         idx_ext;
  logic [31:0]         win_ext;
  logic [63:0]         sum_ext;

  assign in_accept    = in_valid && !in_stall;
  assign out_free     = !out_valid || !out_stall;
  assign idx_ext      = 32'(slot_index);
  assign idx_in_range = idx_ext < 32'(SLOTS);
  assign win_ext      = 32'(win);
  assign sum_ext      = 64'(sum);

  assign walking   = (state == ST_MAX) || (state == ST_SUM) || (state == ST_PICK);
  assign walk_done = (walk_addr == AW'(SLOTS)) && !data_vld;
  assign tickets   = rd_ready ? slot_tickets(top, rd_prio) : '0;
  assign acc_next  = acc + tickets;
  assign draw      = TRIAL_W'(mod_rem) + 1'b1;
  assign pick_hit  = (state == ST_PICK) && data_vld && rd_ready &&
                     (CMP_W'(acc_next) >= CMP_W'(draw));

  lsa_slot_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_en    (issue),
    .rd_addr  (walk_addr[IDX_W-1:0]),
    .rd_ready (rd_ready),
    .rd_prio  (rd_prio)
  );

  lsa_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (lfsr_step(lfsr)),
    .divisor   (sum),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && (func == FUNC_ELECT)) begin
          state_next = ST_MAX;
        end
      end
      ST_MAX: begin
        if (walk_done) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (walk_done) begin
          state_next = any_ready ? ST_LAUNCH : ST_DONE;
        end
      end
      ST_LAUNCH: state_next = ST_DIV;
      ST_DIV: begin
        if (mod_done) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        if (pick_hit) begin
          state_next = ST_WB;
        end
      end
      ST_WB:   state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    issue     = walking && (walk_addr < AW'(SLOTS)) && !pick_hit;
    mod_start = (state == ST_LAUNCH);
    wr        = '0;
    case (state)
      ST_IDLE: begin
        wr.en    = in_accept && (func == FUNC_WRITE) && idx_in_range;
        wr.addr  = idx_ext[IDX_W-1:0];
        wr.ready = ready_in;
        wr.prio  = priority_in;
      end
      ST_WB: begin
        // The winner was ready and stays ready.
        wr.en    = 1'b1;
        wr.addr  = win;
        wr.ready = 1'b1;
        wr.prio  = user_priority;
      end
      default: wr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      seed_value    <= SEED_RESET;
      user_priority <= UPRIO_RESET;
      lfsr          <= '0;
      seeded        <= 1'b0;
      walk_addr     <= '0;
      data_vld      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state    <= state_next;
      data_vld <= issue;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEED:  seed_value    <= cfg_data;
          CFG_UPRIO: user_priority <= cfg_data[PRIO_W-1:0];
          default:   seed_value    <= seed_value;
        endcase
      end
      if (in_accept && (func == FUNC_ELECT) && !seeded) begin
        lfsr   <= seed_value;
        seeded <= 1'b1;
      end else if (state == ST_LAUNCH) begin
        lfsr <= lfsr_step(lfsr);
      end
      if (issue) begin
        walk_addr <= walk_addr + 1'b1;
      end else if (!walking || walk_done) begin
        walk_addr <= '0;
      end
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_idx <= walk_addr[IDX_W-1:0];
    if (in_accept) begin
      top       <= '0;
      any_ready <= 1'b0;
      sum       <= '0;
    end
    if ((state == ST_MAX) && data_vld && rd_ready) begin
      any_ready <= 1'b1;
      if (rd_prio > top) begin
        top <= rd_prio;
      end
    end
    if ((state == ST_SUM) && data_vld) begin
      sum <= sum + tickets;
    end
    if (state == ST_LAUNCH) begin
      acc <= '0;
    end else if ((state == ST_PICK) && data_vld) begin
      acc <= acc_next;
    end
    if (pick_hit) begin
      win <= data_idx;
    end
    if ((state == ST_DONE) && out_free) begin
      found        <= any_ready;
      winner_slot  <= any_ready ? win_ext[SLOT_IN_W-1:0] : '0;
      ticket_total <= any_ready ? sum_ext[TOTAL_W-1:0] : '0;
    end
  end

  `LSA_ASSERT(a_launch_needs_ready, (state != ST_LAUNCH) || any_ready, "launch with no ready slot")
  `LSA_ASSERT(a_mod_done_in_div, !mod_done || (state == ST_DIV), "remainder done outside wait")
  `LSA_ASSERT(a_wb_reached_draw, (state != ST_WB) || (CMP_W'(acc) >= CMP_W'(draw)), "bad winner")
  `LSA_ASSERT_NEXT(a_pick_no_overrun, (state == ST_PICK) && walk_done, 1'b0, "pick walk ended")

endmodule
